### rtl/core/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants for the polyline binomial smoother.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int SUM_WIDTH    = COORD_WIDTH + 4;
   localparam int WINDOW_DEPTH = 4;
   localparam int TAP_COUNT    = WINDOW_DEPTH + 1;
   localparam int MODE_WIDTH   = 2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_START = 2'd0,
      MODE_PATH  = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] x;
   } point_type;

   typedef struct packed {
      logic fill;
      logic shift;
   } cell_ctrl_type;

endpackage

### rtl/core/polyline_binomial_smoother_top.sv
// ----------------------------------------------------------------------------
// polyline_binomial_smoother_top
// 3D path smoother with a 1-4-6-4-1 / 16 binomial filter over a shift window.
// ----------------------------------------------------------------------------
// A run is a start node (tuser 0), path points (tuser 1) and an end node
// (tuser 2). One smoothed point leaves per path point; the end node flushes
// the last two (one if the run had a single path point), the final one with
// tlast high. The block takes one request per cycle while no result waits
// in the job register; an end node that flushes two results holds the input
// while the job register issues its second result. A result passes through
// the job register and then the output register. While a result waits at a
// stalled output, the input keeps taking requests until a further result is
// held in the job register.
module polyline_binomial_smoother_top
   import pbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // point_x, point_y, point_z
   input  logic [1:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // smooth_x, smooth_y, smooth_z
   output logic        rsp_tlast   // last_point
);

   point_type     req_point;
   mode_type      req_mode;
   logic          req_accept;
   cell_ctrl_type cell_ctrl;
   point_type     win_point [WINDOW_DEPTH];
   point_type     chain_in  [WINDOW_DEPTH];

   logic          in_run_ff, in_run_in;
   logic [1:0]    seen_ff, seen_in;
   logic [1:0]    pend_ff, pend_in, pend_left, pend_new;

   point_type     job_win_ff [WINDOW_DEPTH];
   point_type     job_new_ff;
   point_type     tap_pt [TAP_COUNT];

   logic          out_load, issue, issue_tail;
   point_type     smooth_pt;

   logic          rsp_valid_ff, rsp_valid_in;
   point_type     rsp_point_ff;
   logic          rsp_last_ff;

   assign req_point  = point_type'(req_tdata);
   assign req_mode   = mode_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;

   // window chain
   always_comb begin
      cell_ctrl.fill  = req_accept && (req_mode == MODE_START);
      cell_ctrl.shift = req_accept && (req_mode == MODE_PATH) && in_run_ff;
   end

   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      if (k == WINDOW_DEPTH - 1) begin : g_tail
         assign chain_in[k] = req_point;
      end else begin : g_body
         assign chain_in[k] = win_point[k+1];
      end
      pbs_cell u_cell (
         .clock          (clock),
         .ctrl           (cell_ctrl),
         .neighbor_point (chain_in[k]),
         .fill_point     (req_point),
         .slot_point     (win_point[k])
      );
   end

   // run control and pending results
   always_comb begin
      in_run_in = in_run_ff;
      seen_in   = seen_ff;
      pend_new  = 2'b00;
      if (req_accept) begin
         unique case (req_mode)
            MODE_START: begin
               in_run_in = 1'b1;
               seen_in   = 2'd0;
            end
            MODE_PATH: begin
               if (in_run_ff) begin
                  pend_new[0] = (seen_ff >= 2'd2);
                  if (seen_ff != 2'd3) begin
                     seen_in = seen_ff + 2'd1;
                  end
               end
            end
            MODE_END: begin
               if (in_run_ff) begin
                  pend_new[0] = (seen_ff >= 2'd2);
                  pend_new[1] = (seen_ff >= 2'd1);
                  seen_in     = 2'd0;
                  in_run_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign issue      = (pend_ff != 2'b00) && out_load;
   assign issue_tail = !pend_ff[0];

   always_comb begin
      pend_left = pend_ff;
      if (issue) begin
         if (pend_ff[0]) begin
            pend_left[0] = 1'b0;
         end else begin
            pend_left[1] = 1'b0;
         end
      end
   end

   assign req_tready = (pend_left == 2'b00);
   assign pend_in    = req_accept ? pend_new : pend_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         seen_ff   <= 2'd0;
         pend_ff   <= 2'b00;
      end else begin
         in_run_ff <= in_run_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         job_win_ff <= win_point;
         job_new_ff <= req_point;
      end
   end

   // tap select: the tail result repeats the end node
   always_comb begin
      if (issue_tail) begin
         tap_pt[0] = job_win_ff[1];
         tap_pt[1] = job_win_ff[2];
         tap_pt[2] = job_win_ff[3];
         tap_pt[3] = job_new_ff;
         tap_pt[4] = job_new_ff;
      end else begin
         tap_pt[0] = job_win_ff[0];
         tap_pt[1] = job_win_ff[1];
         tap_pt[2] = job_win_ff[2];
         tap_pt[3] = job_win_ff[3];
         tap_pt[4] = job_new_ff;
      end
   end

   pbs_filter u_filter_x (
      .tap_a  (tap_pt[0].x), .tap_b (tap_pt[1].x), .tap_c (tap_pt[2].x),
      .tap_d  (tap_pt[3].x), .tap_e (tap_pt[4].x), .smooth (smooth_pt.x)
   );
   pbs_filter u_filter_y (
      .tap_a  (tap_pt[0].y), .tap_b (tap_pt[1].y), .tap_c (tap_pt[2].y),
      .tap_d  (tap_pt[3].y), .tap_e (tap_pt[4].y), .smooth (smooth_pt.y)
   );
   pbs_filter u_filter_z (
      .tap_a  (tap_pt[0].z), .tap_b (tap_pt[1].z), .tap_c (tap_pt[2].z),
      .tap_d  (tap_pt[3].z), .tap_e (tap_pt[4].z), .smooth (smooth_pt.z)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (issue) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_point_ff <= smooth_pt;
         rsp_last_ff  <= issue_tail;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_point_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_hold_on_double: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'b11) |-> !req_tready)
      else $error("request taken while two results pending");

   a_seen_in_run: assert property (@(posedge clock) disable iff (reset)
      (seen_ff != 2'd0) |-> in_run_ff)
      else $error("path count set outside a run");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_START) |=> (in_run_ff && seen_ff == 2'd0))
      else $error("start node did not open a run");

   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_END && in_run_ff && seen_ff != 2'd0)
      |=> (pend_ff[1] && !in_run_ff))
      else $error("end node did not queue the final result");

   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      issue |=> (rsp_tvalid && rsp_tlast == $past(issue_tail)))
      else $error("last flag does not follow the issued result");
`endif

endmodule

### rtl/core/pbs_cell.sv
// ----------------------------------------------------------------------------
// pbs_cell
// One window slot: holds a control point, loads from its neighbor on a shift
// or from the start node on a fill.
// ----------------------------------------------------------------------------
module pbs_cell
   import pbs_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  point_type     neighbor_point,
   input  point_type     fill_point,
   output point_type     slot_point
);

   point_type slot_ff;
   point_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.fill) begin
         slot_in = fill_point;
      end else if (ctrl.shift) begin
         slot_in = neighbor_point;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_point = slot_ff;

endmodule

### rtl/core/pbs_filter.sv
// ----------------------------------------------------------------------------
// pbs_filter
// Weighted 1-4-6-4-1 sum of five taps, floored by an arithmetic shift by 4.
// ----------------------------------------------------------------------------
module pbs_filter
   import pbs_pkg::*;
(
   input  logic signed [COORD_WIDTH-1:0] tap_a,
   input  logic signed [COORD_WIDTH-1:0] tap_b,
   input  logic signed [COORD_WIDTH-1:0] tap_c,
   input  logic signed [COORD_WIDTH-1:0] tap_d,
   input  logic signed [COORD_WIDTH-1:0] tap_e,
   output logic signed [COORD_WIDTH-1:0] smooth
);

   logic signed [SUM_WIDTH-1:0] ext_a;
   logic signed [SUM_WIDTH-1:0] ext_b;
   logic signed [SUM_WIDTH-1:0] ext_c;
   logic signed [SUM_WIDTH-1:0] ext_d;
   logic signed [SUM_WIDTH-1:0] ext_e;
   logic signed [SUM_WIDTH-1:0] sum;

   assign ext_a = SUM_WIDTH'(tap_a);
   assign ext_b = SUM_WIDTH'(tap_b);
   assign ext_c = SUM_WIDTH'(tap_c);
   assign ext_d = SUM_WIDTH'(tap_d);
   assign ext_e = SUM_WIDTH'(tap_e);

   assign sum = ext_a + (ext_b <<< 2) + (ext_c <<< 2) + (ext_c <<< 1)
              + (ext_d <<< 2) + ext_e;

   assign smooth = sum[SUM_WIDTH-1:4];

endmodule
